>>> design/assert_macros.svh
// Assertion macros shared by the packed pixel blender RTL.
// Included by every file that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define PPB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled during reset
`define PPB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PPB_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define PPB_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

>>> design/ppb_pkg.sv
// Package for the packed pixel blender: pixel type, register codes, constants.
// No dependencies; used by the interfaces and all modules.
package ppb_pkg;

  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    MODE_FROZEN  = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_LIGHTEN = 2'd2
  } blend_mode_t;

  typedef enum logic [1:0] {
    FMT_RGB555 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB888 = 2'd2
  } pixel_format_t;

  // Register code that a write may not store
  localparam logic [1:0] CODE_RESERVED = 2'd3;

  // Register index, taken from paddr bit 2
  localparam logic REG_BLEND_MODE   = 1'b0;
  localparam logic REG_PIXEL_FORMAT = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    blend_mode_t   blend_mode;
    pixel_format_t pixel_format;
  } cfg_t;

  // Format masks
  localparam pixel_t MASK_RGB555 = 24'h007FFF;
  localparam pixel_t MASK_RGB565 = 24'h00FFFF;
  localparam pixel_t MASK_RGB888 = 24'hFFFFFF;

  // Channel maxima and frozen-tint offsets
  localparam logic [7:0] MAX_CH8  = 8'hFF;
  localparam logic [7:0] MAX_CH5  = 8'h1F;
  localparam logic [7:0] MAX_CH6  = 8'h3F;
  localparam logic [9:0] OFS_CH8  = 10'd64;
  localparam logic [9:0] OFS_CH5  = 10'd8;

  // v/3 for v up to 765 as (v * 683) >> 11
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

endpackage

>>> design/ppb_ifs.sv
// Valid/ready channel interfaces for the packed pixel blender.
// Depends on ppb_pkg for the pixel type.
interface ppb_operand_if;
  import ppb_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t source_pixel;
  pixel_t dest_pixel;
  modport source (output valid, source_pixel, dest_pixel, input ready);
  modport sink   (input valid, source_pixel, dest_pixel, output ready);
endinterface

interface ppb_result_if;
  import ppb_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t blended_pixel;
  modport source (output valid, blended_pixel, input ready);
  modport sink   (input valid, blended_pixel, output ready);
endinterface

>>> design/ppb_regs.sv
// APB configuration registers: blend mode and pixel format.
// Depends on ppb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppb_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppb_pkg::DATA_W-1:0]  pwdata,
  output logic [ppb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ppb_pkg::cfg_t               cfg
);
  import ppb_pkg::*;

  logic       wr_en;
  logic [1:0] wr_code;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign wr_code = pwdata[1:0];

  // Register writes; the reserved code is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode   <= MODE_ADD;
      cfg.pixel_format <= FMT_RGB888;
    end else if (wr_en && wr_code != CODE_RESERVED) begin
      case (paddr[2])
        REG_BLEND_MODE:   cfg.blend_mode   <= blend_mode_t'(wr_code);
        REG_PIXEL_FORMAT: cfg.pixel_format <= pixel_format_t'(wr_code);
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_BLEND_MODE:   prdata[1:0] = cfg.blend_mode;
      REG_PIXEL_FORMAT: prdata[1:0] = cfg.pixel_format;
      default: ;
    endcase
  end

  `PPB_ASSERT_NEXT(a_reserved_dropped, clk, rst,
    wr_en && wr_code == CODE_RESERVED, $stable(cfg))
  `PPB_ASSERT_NEXT(a_mode_written, clk, rst,
    wr_en && wr_code != CODE_RESERVED && paddr[2] == REG_BLEND_MODE,
    cfg.blend_mode == $past(wr_code) && $stable(cfg.pixel_format))
  `PPB_ASSERT_NEXT(a_format_written, clk, rst,
    wr_en && wr_code != CODE_RESERVED && paddr[2] == REG_PIXEL_FORMAT,
    cfg.pixel_format == $past(wr_code) && $stable(cfg.blend_mode))

endmodule

>>> design/ppb_blend.sv
// Combinational blend datapath: saturating add, frozen tint and lighten.
// Depends on ppb_pkg; sits between the operand and result registers.
module ppb_blend (
  input  ppb_pkg::cfg_t   cfg,
  input  ppb_pkg::pixel_t source_pixel,
  input  ppb_pkg::pixel_t dest_pixel,
  output ppb_pkg::pixel_t blended_pixel
);
  import ppb_pkg::*;

  // Channel add clamped to the channel maximum
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] max);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, max}) ? max : s[7:0];
  endfunction

  pixel_t     fm, x, y, r_add, r_frz, r_lit, r;
  logic [7:0] fa, fb, fc, ch_max, q3, half_c, lo_c;
  logic [9:0] v, ofs, lo_sum;
  logic [19:0] prod;

  // Format mask
  always_comb begin
    case (cfg.pixel_format)
      FMT_RGB888: fm = MASK_RGB888;
      FMT_RGB565: fm = MASK_RGB565;
      default:    fm = MASK_RGB555;
    endcase
  end

  assign x = source_pixel & fm;
  assign y = dest_pixel & fm;

  // Saturating add per channel
  always_comb begin
    r_add = '0;
    case (cfg.pixel_format)
      FMT_RGB888: begin
        r_add[7:0]   = sat_add(x[7:0],   y[7:0],   MAX_CH8);
        r_add[15:8]  = sat_add(x[15:8],  y[15:8],  MAX_CH8);
        r_add[23:16] = sat_add(x[23:16], y[23:16], MAX_CH8);
      end
      FMT_RGB565: begin
        r_add[4:0]   = 5'(sat_add({3'b0, x[4:0]},   {3'b0, y[4:0]},   MAX_CH5));
        r_add[10:5]  = 6'(sat_add({2'b0, x[10:5]},  {2'b0, y[10:5]},  MAX_CH6));
        r_add[15:11] = 5'(sat_add({3'b0, x[15:11]}, {3'b0, y[15:11]}, MAX_CH5));
      end
      default: begin
        r_add[4:0]   = 5'(sat_add({3'b0, x[4:0]},   {3'b0, y[4:0]},   MAX_CH5));
        r_add[9:5]   = 5'(sat_add({3'b0, x[9:5]},   {3'b0, y[9:5]},   MAX_CH5));
        r_add[14:10] = 5'(sat_add({3'b0, x[14:10]}, {3'b0, y[14:10]}, MAX_CH5));
      end
    endcase
  end

  // Frozen tint: channel pick; 5:6:5 reads the middle channel as 5 bits at shift 6
  always_comb begin
    case (cfg.pixel_format)
      FMT_RGB888: begin
        fa = y[7:0];            fb = y[15:8];           fc = y[23:16];
        ch_max = MAX_CH8;       ofs = OFS_CH8;
      end
      FMT_RGB565: begin
        fa = {3'b0, y[4:0]};    fb = {3'b0, y[10:6]};   fc = {3'b0, y[15:11]};
        ch_max = MAX_CH5;       ofs = OFS_CH5;
      end
      default: begin
        fa = {3'b0, y[4:0]};    fb = {3'b0, y[9:5]};    fc = {3'b0, y[14:10]};
        ch_max = MAX_CH5;       ofs = OFS_CH5;
      end
    endcase
  end

  assign v      = {2'b0, fa} + {2'b0, fb} + {2'b0, fc};
  // divide by three via reciprocal multiply, exact for v <= 765
  assign prod   = 20'(v) * 20'(DIV3_MUL);
  assign q3     = prod[DIV3_SHIFT+7:DIV3_SHIFT];
  assign half_c = ({1'b0, v[9:1]} > {2'b0, ch_max}) ? ch_max : v[8:1];
  assign lo_sum = v + ofs;
  assign lo_c   = (lo_sum > {2'b0, ch_max}) ? ch_max : lo_sum[7:0];

  always_comb begin
    case (cfg.pixel_format)
      FMT_RGB888: r_frz = {q3, half_c, lo_c};
      FMT_RGB565: r_frz = {8'b0, q3[4:0], half_c[4:0], 1'b0, lo_c[4:0]};
      default:    r_frz = {9'b0, q3[4:0], half_c[4:0], lo_c[4:0]};
    endcase
  end

  // Lighten: white in 8:8:8 gives black
  always_comb begin
    if (cfg.pixel_format == FMT_RGB888 && y == MASK_RGB888) begin
      r_lit = '0;
    end else begin
      r_lit = (y != '0) ? fm : '0;
    end
  end

  always_comb begin
    case (cfg.blend_mode)
      MODE_FROZEN:  r = r_frz;
      MODE_LIGHTEN: r = r_lit;
      default:      r = r_add;
    endcase
  end

  assign blended_pixel = r & fm;

endmodule

>>> design/packed_pixel_blender.sv
// Packed pixel blender top level: operand register, blend datapath, result register.
// Depends on ppb_pkg, ppb_ifs, ppb_regs, ppb_blend and assert_macros.svh.
//
//   channel    role   payload                      handshake
//   operands   sink   source_pixel, dest_pixel     valid / ready
//   result     source blended_pixel                valid / ready
//   apb        slave  blend_mode, pixel_format     psel / penable / pready
//
// One item per cycle sustained while result.ready holds; an item passes the
// operand register, then the blend logic, then the result register.
// rst is synchronous, active high: clears both stage valids, mode = add,
// format = 8:8:8.
// A stalled result holds; the operand stage still takes an item while the
// result register is full, so ready drops only when both stages are occupied.
`include "assert_macros.svh"

module packed_pixel_blender (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppb_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppb_pkg::DATA_W-1:0]  pwdata,
  output logic [ppb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  ppb_operand_if.sink                 operands,
  ppb_result_if.source                result
);
  import ppb_pkg::*;

  cfg_t   cfg;
  logic   s1_valid, s1_ready, res_valid, res_ready;
  pixel_t s1_src, s1_dst, blend_out, res_pixel;

  ppb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage readiness
  assign res_ready      = !res_valid || result.ready;
  assign s1_ready       = !s1_valid || res_ready;
  assign operands.ready = s1_ready;

  // Operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operands.valid && s1_ready) begin
      s1_src <= operands.source_pixel;
      s1_dst <= operands.dest_pixel;
    end
  end

  ppb_blend u_blend (
    .cfg           (cfg),
    .source_pixel  (s1_src),
    .dest_pixel    (s1_dst),
    .blended_pixel (blend_out)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && res_ready) begin
      res_pixel <= blend_out;
    end
  end

  assign result.valid         = res_valid;
  assign result.blended_pixel = res_pixel;

  `PPB_ASSERT_NEXT(a_accept_fills_s1, clk, rst,
    operands.valid && operands.ready, s1_valid)
  `PPB_ASSERT_NEXT(a_s1_moves_to_result, clk, rst,
    s1_valid && res_ready, result.valid)
  `PPB_ASSERT_NOW(a_full_blocks_input, clk, rst,
    res_valid && !result.ready && s1_valid, !operands.ready)

endmodule
